>>> rtl/core/fdes_pkg.sv
// ----------------------------------------------------------------------------
// fdes_pkg
// Shared types and constants for the FAT directory entry search unit:
// entry status codes, directory entry layout and register indexes.
// ----------------------------------------------------------------------------
package fdes_pkg;

    // directory entry layout
    localparam int unsigned ENTRY_BYTES    = 32;
    localparam int unsigned OFFSET_W       = $clog2(ENTRY_BYTES);
    localparam int unsigned NAME_LEN       = 11;
    localparam logic [OFFSET_W-1:0] OFS_ATTR       = OFFSET_W'(11);
    localparam logic [OFFSET_W-1:0] OFS_CLUS_HI_LO = OFFSET_W'(20);
    localparam logic [OFFSET_W-1:0] OFS_CLUS_HI_HI = OFFSET_W'(21);
    localparam logic [OFFSET_W-1:0] OFS_CLUS_LO_LO = OFFSET_W'(26);
    localparam logic [OFFSET_W-1:0] OFS_CLUS_LO_HI = OFFSET_W'(27);
    localparam logic [OFFSET_W-1:0] OFS_SIZE_FIRST = OFFSET_W'(28);
    localparam logic [OFFSET_W-1:0] OFS_LAST       = OFFSET_W'(ENTRY_BYTES - 1);

    // special byte values
    localparam logic [7:0] LEAD_END_OF_DIR = 8'h00;
    localparam logic [7:0] LEAD_DELETED    = 8'hE5;
    localparam logic [7:0] ATTR_LONG_NAME  = 8'h0F;
    localparam logic [7:0] ATTR_DIR_MASK   = 8'h10;

    // first cluster of the data area
    localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_FIRST_EIGHT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_LAST_THREE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_AREA_START  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CLUSTER_SECTORS  = 2'd3;

    // entry status codes
    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_DELETED  = 3'd1,
        ST_LONGNAME = 3'd2,
        ST_DIR      = 3'd3,
        ST_MATCH    = 3'd4,
        ST_END      = 3'd5
    } t_entry_status;

    // finished entry handed from the parser to the result stage
    typedef struct packed {
        t_entry_status status;
        logic [31:0]   cluster;
        logic [31:0]   size;
    } t_entry_info;

endpackage

>>> rtl/core/fdes_in_if.sv
// ----------------------------------------------------------------------------
// fdes_in_if
// Directory byte channel: one byte of sector data and a scan start flag.
// ----------------------------------------------------------------------------
interface fdes_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       scan_start;

    modport source (output valid, output data_byte, output scan_start, input ready);
    modport sink   (input valid, input data_byte, input scan_start, output ready);
endinterface

>>> rtl/core/fdes_out_if.sv
// ----------------------------------------------------------------------------
// fdes_out_if
// Entry result channel: status, first cluster, file size and first sector.
// ----------------------------------------------------------------------------
interface fdes_out_if;
    logic                  valid;
    logic                  ready;
    fdes_pkg::t_entry_status entry_status;
    logic [31:0]           start_cluster;
    logic [31:0]           size_bytes;
    logic [31:0]           start_sector;

    modport source (
        output valid, output entry_status, output start_cluster,
        output size_bytes, output start_sector, input ready
    );
    modport sink (
        input valid, input entry_status, input start_cluster,
        input size_bytes, input start_sector, output ready
    );
endinterface

>>> rtl/core/fdes_entry_parse.sv
// ----------------------------------------------------------------------------
// fdes_entry_parse
// Walks the bytes of 32-byte directory entries, compares the short name,
// captures attribute, cluster and size, and classifies the entry on its
// last byte. Holds the search done flag.
// ----------------------------------------------------------------------------
module fdes_entry_parse (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_scan_start,
    input  logic [63:0]             i_name_first_eight,
    input  logic [23:0]             i_name_last_three,
    output logic                    o_last,
    output fdes_pkg::t_entry_info   o_info
);

    localparam int unsigned OW = fdes_pkg::OFFSET_W;

    logic [OW-1:0] r_offset, n_offset;
    logic          r_match,  n_match;
    logic [7:0]    r_lead,   n_lead;
    logic [7:0]    r_attr,   n_attr;
    logic [31:0]   r_cluster, n_cluster;
    logic [31:0]   r_size,   n_size;
    logic          r_done,   n_done;

    logic          w_active;
    logic [OW-1:0] w_off;
    logic [87:0]   w_name;
    logic [7:0]    w_wanted;
    logic          w_eq;
    fdes_pkg::t_entry_status w_status;

    // effective offset and whether this byte is processed
    assign w_active = i_scan_start || !r_done;
    assign w_off    = i_scan_start ? '0 : r_offset;

    // wanted name byte at this offset
    assign w_name   = {i_name_last_three, i_name_first_eight};
    assign w_wanted = (w_off < OW'(fdes_pkg::NAME_LEN)) ? w_name[{w_off[3:0], 3'b000} +: 8]
                                                         : 8'h00;
    assign w_eq     = (i_data_byte == w_wanted);

    // entry classification, end of directory first
    always_comb begin
        priority if (r_lead == fdes_pkg::LEAD_END_OF_DIR) begin
            w_status = fdes_pkg::ST_END;
        end else if (r_lead == fdes_pkg::LEAD_DELETED) begin
            w_status = fdes_pkg::ST_DELETED;
        end else if (r_attr == fdes_pkg::ATTR_LONG_NAME) begin
            w_status = fdes_pkg::ST_LONGNAME;
        end else if ((r_attr & fdes_pkg::ATTR_DIR_MASK) != 8'h00) begin
            w_status = fdes_pkg::ST_DIR;
        end else if (r_match) begin
            w_status = fdes_pkg::ST_MATCH;
        end else begin
            w_status = fdes_pkg::ST_NONE;
        end
    end

    // result of the entry that closes with this byte
    assign o_last         = i_accept && w_active && (w_off == fdes_pkg::OFS_LAST);
    assign o_info.status  = w_status;
    assign o_info.cluster = r_cluster;
    assign o_info.size    = {i_data_byte, r_size[23:0]};

    // capture of entry fields
    always_comb begin
        n_offset  = r_offset;
        n_match   = r_match;
        n_lead    = r_lead;
        n_attr    = r_attr;
        n_cluster = r_cluster;
        n_size    = r_size;
        n_done    = r_done;
        if (i_accept && w_active) begin
            if (w_off < OW'(fdes_pkg::NAME_LEN)) begin
                if (w_off == '0) begin
                    n_lead  = i_data_byte;
                    n_match = w_eq;
                end else if (!w_eq) begin
                    n_match = 1'b0;
                end
            end else if (w_off == fdes_pkg::OFS_ATTR) begin
                n_attr = i_data_byte;
            end else if (w_off == fdes_pkg::OFS_CLUS_HI_LO) begin
                n_cluster[23:16] = i_data_byte;
            end else if (w_off == fdes_pkg::OFS_CLUS_HI_HI) begin
                n_cluster[31:24] = i_data_byte;
            end else if (w_off == fdes_pkg::OFS_CLUS_LO_LO) begin
                n_cluster[7:0] = i_data_byte;
            end else if (w_off == fdes_pkg::OFS_CLUS_LO_HI) begin
                n_cluster[15:8] = i_data_byte;
            end else if (w_off >= fdes_pkg::OFS_SIZE_FIRST) begin
                n_size[{w_off[1:0], 3'b000} +: 8] = i_data_byte;
            end
            n_offset = w_off + OW'(1);
            // a match or end of directory stops the search
            if (w_off == fdes_pkg::OFS_LAST) begin
                n_done = (w_status == fdes_pkg::ST_END) || (w_status == fdes_pkg::ST_MATCH);
            end else begin
                n_done = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_match   <= 1'b1;
            r_lead    <= 8'h00;
            r_attr    <= 8'h00;
            r_cluster <= '0;
            r_size    <= '0;
            r_done    <= 1'b0;
        end else begin
            r_offset  <= n_offset;
            r_match   <= n_match;
            r_lead    <= n_lead;
            r_attr    <= n_attr;
            r_cluster <= n_cluster;
            r_size    <= n_size;
            r_done    <= n_done;
        end
    end

endmodule

>>> rtl/core/fat_directory_entry_search_unit.sv
// ----------------------------------------------------------------------------
// fat_directory_entry_search_unit
// Short-name lookup over a stream of FAT32 directory entry bytes.
// ----------------------------------------------------------------------------
// The unit takes one directory byte per cycle and groups the bytes into
// 32-byte entries. On the last byte of each entry it loads one result into
// an output register: the entry status, the first cluster, the file size
// and the cluster's first sector. The input is ready whenever the output
// register is empty or being drained, so the sustained rate is one byte
// per clock; a result held by the sink stalls every input byte until it is
// taken. After a match or an end-of-directory entry bytes are dropped
// until a byte arrives with scan_start set. Write registers through the
// plain write port while no result is pending; the unit does not check.
module fat_directory_entry_search_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [fdes_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [fdes_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    fdes_in_if.sink                               i_in,
    fdes_out_if.source                            o_out
);

    // configuration registers
    logic [63:0] r_name_first_eight;
    logic [23:0] r_name_last_three;
    logic [31:0] r_data_area_start;
    logic [7:0]  r_cluster_sectors;

    // output register
    logic                    r_out_valid, n_out_valid;
    fdes_pkg::t_entry_status r_out_status, n_out_status;
    logic [31:0]             r_out_cluster, n_out_cluster;
    logic [31:0]             r_out_size, n_out_size;
    logic [31:0]             r_out_sector, n_out_sector;

    logic                    w_accept;
    logic                    w_last;
    fdes_pkg::t_entry_info   w_info;
    logic [31:0]             w_product;

    // input transfer
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    fdes_entry_parse u_parse (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (w_accept),
        .i_data_byte        (i_in.data_byte),
        .i_scan_start       (i_in.scan_start),
        .i_name_first_eight (r_name_first_eight),
        .i_name_last_three  (r_name_last_three),
        .o_last             (w_last),
        .o_info             (w_info)
    );

    // first sector of the start cluster, modulo 2^32
    assign w_product = (w_info.cluster - fdes_pkg::FIRST_DATA_CLUSTER)
                       * {24'd0, r_cluster_sectors};

    // output register load and drain
    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_cluster = r_out_cluster;
        n_out_size    = r_out_size;
        n_out_sector  = r_out_sector;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_last) begin
            n_out_valid   = 1'b1;
            n_out_status  = w_info.status;
            n_out_cluster = w_info.cluster;
            n_out_size    = w_info.size;
            n_out_sector  = w_product + r_data_area_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out_status  <= n_out_status;
        r_out_cluster <= n_out_cluster;
        r_out_size    <= n_out_size;
        r_out_sector  <= n_out_sector;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.entry_status  = r_out_status;
    assign o_out.start_cluster = r_out_cluster;
    assign o_out.size_bytes    = r_out_size;
    assign o_out.start_sector  = r_out_sector;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_first_eight <= '0;
            r_name_last_three  <= '0;
            r_data_area_start  <= '0;
            r_cluster_sectors  <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fdes_pkg::REG_NAME_FIRST_EIGHT: r_name_first_eight <= i_cfg_data;
                fdes_pkg::REG_NAME_LAST_THREE:  r_name_last_three  <= i_cfg_data[23:0];
                fdes_pkg::REG_DATA_AREA_START:  r_data_area_start  <= i_cfg_data[31:0];
                fdes_pkg::REG_CLUSTER_SECTORS:  r_cluster_sectors  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

>>> tb/fat_directory_entry_search_unit_tb.sv
// ----------------------------------------------------------------------------
// fat_directory_entry_search_unit_tb
// Self-checking bench for the FAT32 short-name directory search unit. A
// table of directed directory entries comes first: reset values, extreme
// clusters, every status and restarts. Randomized directory streams follow,
// run under several name and geometry settings. Every entry result is
// checked against a typed-in result or a cycle-free model of the search,
// with random stalls on both channels outside one phase.
// ----------------------------------------------------------------------------
module fat_directory_entry_search_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one entry result as the block reports it
    typedef struct packed {
        fdes_pkg::t_entry_status status;
        logic [31:0]   cluster;
        logic [31:0]   size;
        logic [31:0]   sector;
    } t_entry_result;

    // one directory entry to stream, with an optional typed-in result
    typedef struct packed {
        logic [87:0]   name;
        logic [7:0]    attr;
        logic [31:0]   cluster;
        logic [31:0]   size;
        logic          scan;
        logic [5:0]    len;
        logic [1:0]    setting;
        logic          typed;
        t_entry_result want;
    } t_dir_row;

    // one register setting: wanted name, data area start, sectors per cluster
    typedef struct packed {
        logic [87:0] name;
        logic [31:0] area_base;
        logic [7:0]  spc;
    } t_dir_setting;

    localparam int DIR_ROWS = 18;
    localparam logic [87:0] NAME_README   = {24'h545854, 64'h2020454D44414552};
    localparam logic [87:0] NAME_ALL_ONES = {88{1'b1}};
    localparam logic [87:0] NAME_LEAD_A   = {80'd0, 8'h41};

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             cfg_we;
    logic [fdes_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [fdes_pkg::CFG_DATA_W-1:0]  cfg_data;

    fdes_in_if  in_ch ();
    fdes_out_if out_ch ();

    fat_directory_entry_search_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // sideband that travels with each byte: typed-in result for the row
    logic          tag_typed;
    t_entry_result tag_result;

    // model copy of the registers
    logic [87:0] m_name;
    logic [31:0] m_area_base;
    logic [7:0]  m_spc;

    // model copy of the search state
    logic [4:0]  m_offset;
    logic        m_name_ok;
    logic [7:0]  m_lead;
    logic [7:0]  m_attr;
    logic [31:0] m_cluster;
    logic [31:0] m_size;
    logic        m_done;

    t_entry_result pending_entries [$];
    int            mismatch_count;
    int            live_bytes;
    int unsigned   src_idle_pct;
    int unsigned   snk_idle_pct;

    // driver view of the current wanted name
    logic [87:0]   cur_name;
    int            cur_setting;

    t_dir_row      plan [DIR_ROWS];
    t_dir_setting  settings [3];

    // clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatch_count++;
    endtask

    // one byte through the search model; got is set on the closing byte
    task automatic dir_search_step(input logic [7:0] b, input logic st,
                                   output logic got, output t_entry_result res);
        logic [4:0]              o;
        logic [7:0]              want_b;
        fdes_pkg::t_entry_status s;
        got = 1'b0;
        res = '0;
        if (st) begin
            m_offset = '0;
            m_done   = 1'b0;
        end
        if (!m_done) begin
            live_bytes++;
            o = m_offset;
            if (o < 5'd11) begin
                want_b = m_name[8*o +: 8];
                if (o == 5'd0) begin
                    m_lead    = b;
                    m_name_ok = (b == want_b);
                end else if (b != want_b) begin
                    m_name_ok = 1'b0;
                end
            end else if (o == 5'd11) begin
                m_attr = b;
            end else if (o == 5'd20) begin
                m_cluster[23:16] = b;
            end else if (o == 5'd21) begin
                m_cluster[31:24] = b;
            end else if (o == 5'd26) begin
                m_cluster[7:0] = b;
            end else if (o == 5'd27) begin
                m_cluster[15:8] = b;
            end else if (o >= 5'd28) begin
                m_size[8*(o-5'd28) +: 8] = b;
            end
            m_offset = o + 5'd1;
            if (o == 5'd31) begin
                if (m_lead == fdes_pkg::LEAD_END_OF_DIR)            s = fdes_pkg::ST_END;
                else if (m_lead == fdes_pkg::LEAD_DELETED)          s = fdes_pkg::ST_DELETED;
                else if (m_attr == fdes_pkg::ATTR_LONG_NAME)        s = fdes_pkg::ST_LONGNAME;
                else if ((m_attr & fdes_pkg::ATTR_DIR_MASK) != 8'd0) s = fdes_pkg::ST_DIR;
                else if (m_name_ok)                                 s = fdes_pkg::ST_MATCH;
                else                                                s = fdes_pkg::ST_NONE;
                if (s == fdes_pkg::ST_END || s == fdes_pkg::ST_MATCH) m_done = 1'b1;
                res.status  = s;
                res.cluster = m_cluster;
                res.size    = m_size;
                res.sector  = (m_cluster - fdes_pkg::FIRST_DATA_CLUSTER) * {24'd0, m_spc}
                              + m_area_base;
                got = 1'b1;
            end
        end
    endtask

    // output sink with random back-pressure
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // register shadow, prediction on each input transfer, check on each output
    always @(posedge i_clk) begin : watch
        logic          got;
        t_entry_result res;
        t_entry_result exp_res;
        if (!i_rst_n) begin
            m_name       = '0;
            m_area_base  = '0;
            m_spc        = 8'd1;
            m_offset     = '0;
            m_name_ok    = 1'b1;
            m_lead       = '0;
            m_attr       = '0;
            m_cluster    = '0;
            m_size       = '0;
            m_done       = 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    fdes_pkg::REG_NAME_FIRST_EIGHT: m_name[63:0]  = cfg_data[63:0];
                    fdes_pkg::REG_NAME_LAST_THREE:  m_name[87:64] = cfg_data[23:0];
                    fdes_pkg::REG_DATA_AREA_START:  m_area_base   = cfg_data[31:0];
                    fdes_pkg::REG_CLUSTER_SECTORS:  m_spc         = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                dir_search_step(in_ch.data_byte, in_ch.scan_start, got, res);
                if (got) pending_entries.push_back(tag_typed ? tag_result : res);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (pending_entries.size() == 0) begin
                    note_mismatch("result with nothing pending", 32'(out_ch.entry_status),
                                  32'd0);
                end else begin
                    exp_res = pending_entries.pop_front();
                    if (out_ch.entry_status != exp_res.status)
                        note_mismatch("entry_status", 32'(out_ch.entry_status),
                                      32'(exp_res.status));
                    if (out_ch.start_cluster != exp_res.cluster)
                        note_mismatch("start_cluster", out_ch.start_cluster, exp_res.cluster);
                    if (out_ch.size_bytes != exp_res.size)
                        note_mismatch("size_bytes", out_ch.size_bytes, exp_res.size);
                    if (out_ch.start_sector != exp_res.sector)
                        note_mismatch("start_sector", out_ch.start_sector, exp_res.sector);
                end
            end
        end
    end

    function automatic t_dir_row mk_row(input logic [87:0] name, input logic [7:0] attr,
                                        input logic [31:0] cluster, input logic [31:0] size,
                                        input logic scan, input logic [5:0] len,
                                        input logic [1:0] setting);
        t_dir_row r;
        r         = '0;
        r.name    = name;
        r.attr    = attr;
        r.cluster = cluster;
        r.size    = size;
        r.scan    = scan;
        r.len     = len;
        r.setting = setting;
        return r;
    endfunction

    function automatic t_dir_row typed_row(input t_dir_row r,
                                           input fdes_pkg::t_entry_status s,
                                           input logic [31:0] sector);
        t_dir_row t;
        t              = r;
        t.typed        = 1'b1;
        t.want.status  = s;
        t.want.cluster = r.cluster;
        t.want.size    = r.size;
        t.want.sector  = sector;
        return t;
    endfunction

    // byte at a given offset of an entry; unused bytes are random filler
    function automatic logic [7:0] row_byte(input t_dir_row r, input int o);
        logic [7:0] b;
        if (o < 11)       b = r.name[8*o +: 8];
        else if (o == 11) b = r.attr;
        else if (o == 20) b = r.cluster[23:16];
        else if (o == 21) b = r.cluster[31:24];
        else if (o == 26) b = r.cluster[7:0];
        else if (o == 27) b = r.cluster[15:8];
        else if (o >= 28) b = r.size[8*(o-28) +: 8];
        else              b = 8'($urandom_range(255));
        return b;
    endfunction

    // true when the entry finishes the search under the current name
    function automatic logic closes(input t_dir_row r);
        logic [7:0] lead;
        lead = r.name[7:0];
        return lead == fdes_pkg::LEAD_END_OF_DIR ||
               (lead != fdes_pkg::LEAD_DELETED && r.attr != fdes_pkg::ATTR_LONG_NAME &&
                (r.attr & fdes_pkg::ATTR_DIR_MASK) == 8'd0 && r.name == cur_name);
    endfunction

    // random entry, mostly well formed around the wanted name
    function automatic t_dir_row rand_row(input logic scan_now);
        t_dir_row    r;
        int unsigned p;
        int unsigned idx;
        r = '0;
        p = $urandom_range(99);
        r.name = cur_name;
        if (p >= 35 && p < 55) begin
            idx = $urandom_range(10);
            r.name[8*idx +: 8] = r.name[8*idx +: 8] ^ 8'($urandom_range(255, 1));
        end else if (p >= 55) begin
            r.name[31:0]  = $urandom();
            r.name[63:32] = $urandom();
            r.name[87:64] = 24'($urandom());
        end
        p = $urandom_range(99);
        if (p < 10)      r.name[7:0] = fdes_pkg::LEAD_END_OF_DIR;
        else if (p < 20) r.name[7:0] = fdes_pkg::LEAD_DELETED;
        p = $urandom_range(99);
        if (p < 12)      r.attr = fdes_pkg::ATTR_LONG_NAME;
        else if (p < 27) r.attr = 8'($urandom_range(255)) | fdes_pkg::ATTR_DIR_MASK;
        else             r.attr = 8'($urandom_range(255)) & ~fdes_pkg::ATTR_DIR_MASK;
        if ($urandom_range(99) < 12) begin
            case ($urandom_range(3))
                0:       r.cluster = 32'd0;
                1:       r.cluster = 32'd1;
                2:       r.cluster = fdes_pkg::FIRST_DATA_CLUSTER;
                default: r.cluster = '1;
            endcase
        end else begin
            r.cluster = $urandom();
        end
        r.size = $urandom();
        r.scan = scan_now;
        r.len  = ($urandom_range(99) < 4) ? 6'($urandom_range(31, 1)) : 6'd32;
        return r;
    endfunction

    // one byte transfer with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic st, input logic typed,
                             input t_entry_result want);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.scan_start <= st;
        tag_typed        <= typed;
        tag_result       <= want;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_row(input t_dir_row r);
        for (int o = 0; o < int'(r.len); o++)
            send_byte(row_byte(r, o), r.scan && o == 0, r.typed, r.want);
    endtask

    // hold the input until every pending result is out, then let it settle
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [fdes_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [fdes_pkg::CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input t_dir_setting s);
        drain_results();
        cfg_write(fdes_pkg::REG_NAME_FIRST_EIGHT, s.name[63:0]);
        cfg_write(fdes_pkg::REG_NAME_LAST_THREE, {40'd0, s.name[87:64]});
        cfg_write(fdes_pkg::REG_DATA_AREA_START, {32'd0, s.area_base});
        cfg_write(fdes_pkg::REG_CLUSTER_SECTORS, {56'd0, s.spc});
        cfg_we   <= 1'b0;
        cur_name = s.name;
    endtask

    // run limit
    initial begin
        #2ms;
        $display("fat_directory_entry_search_unit verification failed");
        $finish;
    end

    initial begin : stimulus
        t_dir_row     r;
        t_dir_setting s;
        logic         scan_now;
        logic         closed;
        logic         force_scan;
        int           phase_base;
        int           wait_cycles;

        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.scan_start = 1'b0;
        out_ch.ready     = 1'b0;
        tag_typed        = 1'b0;
        tag_result       = '0;
        mismatch_count   = 0;
        live_bytes       = 0;
        src_idle_pct     = 34;
        snk_idle_pct     = 34;
        cur_name         = '0;
        cur_setting      = 0;

        // reset values, a readme name, then all-ones extremes
        settings[0] = '{name: '0, area_base: 32'd0, spc: 8'd1};
        settings[1] = '{name: NAME_README, area_base: 32'h0000_1000, spc: 8'd8};
        settings[2] = '{name: NAME_ALL_ONES, area_base: 32'hFFFF_FFFF, spc: 8'd255};

        // entries under reset values: every status but match
        plan[0]  = typed_row(mk_row('0, 8'h00, 32'd2, 32'd0, 1'b1, 6'd32, 2'd0),
                             fdes_pkg::ST_END, 32'd0);
        plan[1]  = typed_row(mk_row({80'd0, fdes_pkg::LEAD_DELETED}, 8'h00, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 1'b1, 6'd32, 2'd0),
                             fdes_pkg::ST_DELETED, 32'hFFFF_FFFD);
        plan[2]  = typed_row(mk_row(NAME_LEAD_A, fdes_pkg::ATTR_LONG_NAME, 32'd3, 32'd1,
                                    1'b0, 6'd32, 2'd0),
                             fdes_pkg::ST_LONGNAME, 32'd1);
        plan[3]  = typed_row(mk_row(NAME_LEAD_A, fdes_pkg::ATTR_DIR_MASK, 32'd0, 32'h1234,
                                    1'b0, 6'd32, 2'd0),
                             fdes_pkg::ST_DIR, 32'hFFFF_FFFE);
        plan[4]  = mk_row(NAME_LEAD_A, 8'hFF, 32'd5, 32'h8000_0000, 1'b0, 6'd32, 2'd0);
        plan[5]  = mk_row({64'd0, 24'h4F4F46}, 8'h20, 32'd10, 32'd77, 1'b0, 6'd32, 2'd0);
        // readme name: match, ignored entry, restart mid-entry, near misses
        plan[6]  = mk_row(NAME_README, 8'h20, 32'h0001_0002, 32'h400, 1'b1, 6'd32, 2'd1);
        plan[7]  = mk_row(NAME_README, 8'h00, 32'd9, 32'd9, 1'b0, 6'd32, 2'd1);
        plan[8]  = mk_row(NAME_README, 8'h00, 32'd9, 32'd9, 1'b1, 6'd10, 2'd1);
        plan[9]  = mk_row(NAME_README ^ {8'h01, 80'd0}, 8'h00, 32'd40, 32'd1, 1'b1,
                          6'd32, 2'd1);
        plan[10] = mk_row(NAME_README ^ {80'd0, 8'h01}, 8'h00, 32'd41, 32'd2, 1'b0,
                          6'd32, 2'd1);
        plan[11] = mk_row(NAME_README, fdes_pkg::ATTR_LONG_NAME, 32'd42, 32'd3, 1'b0,
                          6'd32, 2'd1);
        plan[12] = mk_row(NAME_README, fdes_pkg::ATTR_DIR_MASK, 32'd43, 32'd4, 1'b0,
                          6'd32, 2'd1);
        plan[13] = mk_row({NAME_README[87:8], fdes_pkg::LEAD_DELETED}, 8'h00, 32'd44,
                          32'd5, 1'b0, 6'd32, 2'd1);
        plan[14] = typed_row(mk_row(NAME_README, 8'h01, 32'd2, 32'd5000, 1'b0, 6'd32,
                                    2'd1),
                             fdes_pkg::ST_MATCH, 32'h0000_1000);
        // all-ones name and geometry: wrapping sector arithmetic
        plan[15] = mk_row(NAME_ALL_ONES, 8'h00, 32'hFFFF_FFFF, 32'd0, 1'b1, 6'd32, 2'd2);
        plan[16] = mk_row(NAME_ALL_ONES ^ {40'd0, 8'hFF, 40'd0}, 8'h00, 32'd1,
                          32'hFFFF_FFFF, 1'b1, 6'd32, 2'd2);
        plan[17] = typed_row(mk_row('0, 8'h00, 32'd2, 32'd0, 1'b0, 6'd32, 2'd2),
                             fdes_pkg::ST_END, 32'hFFFF_FFFF);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed entries
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (int'(plan[i].setting) != cur_setting) begin
                cur_setting = int'(plan[i].setting);
                apply_setting(settings[cur_setting]);
            end
            send_row(plan[i]);
        end

        // random directory streams, one register setting per phase
        for (int ph = 0; ph < 5; ph++) begin
            s.name[31:0]  = $urandom();
            s.name[63:32] = $urandom();
            s.name[87:64] = 24'($urandom());
            if (s.name[7:0] == fdes_pkg::LEAD_END_OF_DIR ||
                s.name[7:0] == fdes_pkg::LEAD_DELETED)
                s.name[7:0] = 8'h41;
            if (ph == 0) begin
                s.area_base = 32'd0;
                s.spc       = 8'd1;
            end else if (ph == 1) begin
                s.area_base = '1;
                s.spc       = 8'd255;
            end else begin
                s.area_base = $urandom();
                s.spc       = 8'($urandom_range(255, 1));
            end
            apply_setting(s);
            // one phase runs with no idling on either side
            src_idle_pct = (ph == 2) ? 0 : 34;
            snk_idle_pct = (ph == 2) ? 0 : 34;
            phase_base   = live_bytes;
            force_scan   = 1'b1;
            closed       = 1'b0;
            while (live_bytes - phase_base < 260) begin
                scan_now = force_scan ||
                           (closed ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0));
                r = rand_row(scan_now);
                send_row(r);
                if (r.len != 6'd32) begin
                    force_scan = 1'b1;
                end else begin
                    force_scan = 1'b0;
                    if (r.scan || !closed) closed = closes(r);
                end
            end
        end

        // let everything drain and settle, then report
        in_ch.valid <= 1'b0;
        wait_cycles = 0;
        while (pending_entries.size() != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_entries.size() != 0)
            note_mismatch("results never delivered", 32'(pending_entries.size()), 32'd0);

        if (mismatch_count == 0) begin
            $display("fat_directory_entry_search_unit verification clean");
        end else begin
            $display("fat_directory_entry_search_unit verification failed");
        end
        $finish;
    end

endmodule
